[rtl/core/smk_pkg.sv]
`timescale 1ns / 1ps
// smk_pkg: shared types, constants and arctangent table for the swerve module
// kinematics unit. No dependencies.
package smk_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int FRAC_BITS_DEF    = 12;
	localparam int MAX_STEPS        = 24;
	localparam int GUARD            = 8;
	localparam int ZW               = 35;   // Q5.30 angle accumulator, signed
	localparam int RW               = 19;   // rebuilt wheel vector x / y
	localparam int R2W              = 32;   // w^2 + b^2
	localparam int ANG_LIM          = 25736;

	localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;

	localparam logic [29:0] ATAN_TAB [MAX_STEPS] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
	};

	typedef enum logic {
		CFG_POS_W = 1'b0,
		CFG_POS_B = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] omega;
		logic signed [19:0] acc_vx;
		logic signed [19:0] acc_vy;
		logic signed [19:0] acc_omega;
	} smk_in_t;

	typedef struct packed {
		logic [16:0]        wheel_speed;
		logic signed [15:0] wheel_angle;
		logic signed [19:0] sum_vx;
		logic signed [19:0] sum_vy;
		logic signed [19:0] sum_omega;
		logic               saturated;
	} smk_out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VMB,
		ST_VMW,
		ST_VPRE,
		ST_RPRE,
		ST_CWAIT,
		ST_VMAG,
		ST_VFIN,
		ST_RFIN,
		ST_R2A,
		ST_R2B,
		ST_PB,
		ST_PW,
		ST_DIVGO,
		ST_DIV,
		ST_OMEGA,
		ST_OUT
	} smk_state_t;

endpackage

[rtl/core/swerve_module_kinematics_unit.sv]
`timescale 1ns / 1ps
// Swerve module kinematics: wheel command from chassis velocity (type 0) and
// chassis velocity accumulation from the stored wheel vector (type 1).
// Type 0 skips the CORDIC cell chain for a zero wheel vector; type 1 runs the
// 37 + FRAC_BITS bit divider only when w^2 + b^2 exceeds R2_MIN. One item at a
// time through the CORDIC cell chain; the next item is taken once the result sits
// in the output register. Reset clears pos_w, pos_b and the stores.
module swerve_module_kinematics_unit #(
	parameter int CORDIC_STEPS = smk_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = smk_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  smk_pkg::smk_in_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output smk_pkg::smk_out_t out_data
);
	import smk_pkg::*;

	localparam int VIW = (32 - FRAC_BITS > 17) ? 32 - FRAC_BITS : 17;
	localparam int XW  = VIW + 11;
	localparam int MW  = XW + 31;
	localparam int DW  = 36;
	localparam int DVW = DW + FRAC_BITS + 1;
	localparam int SW  = DVW + 1;
	localparam logic [R2W-1:0] R2_MIN =
		R2W'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);
	localparam logic signed [32:0] RND_F = {{(33-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic signed [MW-1:0] RND_M = {{(XW-7){1'b0}}, 1'b1, 37'b0};

	smk_state_t state_q, state_d;

	smk_in_t                it_q;
	logic signed [15:0]     pos_w_q, pos_b_q;
	logic [16:0]            speed_q;
	logic signed [15:0]     angle_q;
	logic signed [VIW-1:0]  vix_q, viy_q;
	logic signed [XW-1:0]   x0_q, y0_q;
	logic signed [ZW-1:0]   z0_q;
	logic                   rot0_q, start_q, zero_q, neg_q, dneg_q, flag_q;
	logic signed [MW-1:0]   mprod_q;
	logic signed [RW-1:0]   xr_q, yr_q;
	logic [R2W-1:0]         r2_q;
	logic signed [34:0]     pb_q;
	logic signed [DW-1:0]   diff_q;
	logic signed [19:0]     svx_q, svy_q, som_q;
	smk_out_t               out_q;
	logic                   out_valid_q;

	logic                   accept, div_start, div_done, out_load, r2_big;
	logic [DVW-1:0]         div_dividend, div_quot;

	// CORDIC cell chain
	logic                   cv   [CORDIC_STEPS+1];
	logic                   crot [CORDIC_STEPS+1];
	logic signed [XW-1:0]   cx   [CORDIC_STEPS+1];
	logic signed [XW-1:0]   cy   [CORDIC_STEPS+1];
	logic signed [ZW-1:0]   cz   [CORDIC_STEPS+1];

	assign cv[0]   = start_q;
	assign crot[0] = rot0_q;
	assign cx[0]   = x0_q;
	assign cy[0]   = y0_q;
	assign cz[0]   = z0_q;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		smk_cordic_cell #(
			.XW    (XW),
			.SHIFT (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (cv[i]),
			.rot_in (crot[i]),
			.x_in   (cx[i]),
			.y_in   (cy[i]),
			.z_in   (cz[i]),
			.vld_q  (cv[i+1]),
			.rot_q  (crot[i+1]),
			.x_q    (cx[i+1]),
			.y_q    (cy[i+1]),
			.z_q    (cz[i+1])
		);
	end

	// ---------------- combinational datapath ----------------
	logic signed [15:0]     mul_op;
	logic signed [31:0]     om_prod;
	logic signed [32:0]     om_rnd;
	logic signed [33:0]     vx_sum, vy_sum;
	logic signed [VIW:0]    ax, ay;
	logic [46:0]            sp_prod;
	logic [55:0]            sp_rnd;
	logic signed [ZW-1:0]   za;
	logic signed [MW-1:0]   m_rnd;
	logic signed [ZW-1:0]   z_rnd;
	logic signed [XW-1:0]   xs, ys;
	logic signed [31:0]     ww, bb;
	logic signed [20:0]     sx_sum, sy_sum;
	logic signed [34:0]     yw;
	logic [DW-1:0]          dabs;
	logic signed [SW-1:0]   t_val;
	logic signed [SW:0]     so_sum;

	assign mul_op  = (state_q == ST_VMB) ? pos_b_q : pos_w_q;
	assign om_prod = it_q.omega * mul_op;
	assign om_rnd  = ($signed({om_prod[31], om_prod}) + RND_F) >>> FRAC_BITS;
	assign vx_sum  = $signed({{18{it_q.vel_x[15]}}, it_q.vel_x}) + $signed({om_rnd[32], om_rnd});
	assign vy_sum  = $signed({{18{it_q.vel_y[15]}}, it_q.vel_y}) - $signed({om_rnd[32], om_rnd});

	assign ax = vix_q[VIW-1] ? -$signed({vix_q[VIW-1], vix_q}) : $signed({vix_q[VIW-1], vix_q});
	assign ay = vix_q[VIW-1] ? -$signed({viy_q[VIW-1], viy_q}) : $signed({viy_q[VIW-1], viy_q});

	assign sp_prod = speed_q * INV_GAIN_Q30;
	assign sp_rnd  = {1'b0, sp_prod, 8'b0} + (56'd1 << 29);
	assign za      = $signed({{(ZW-16){angle_q[15]}}, angle_q}) <<< 17;

	assign m_rnd = (mprod_q + RND_M) >>> 38;
	assign z_rnd = (cz[CORDIC_STEPS] + $signed({{(ZW-17){1'b0}}, 17'h10000})) >>> 17;
	assign xs    = (cx[CORDIC_STEPS] + $signed({{(XW-8){1'b0}}, 8'h80})) >>> GUARD;
	assign ys    = (cy[CORDIC_STEPS] + $signed({{(XW-8){1'b0}}, 8'h80})) >>> GUARD;

	assign ww     = pos_w_q * pos_w_q;
	assign bb     = pos_b_q * pos_b_q;
	assign sx_sum = $signed({it_q.acc_vx[19], it_q.acc_vx}) + $signed({{2{xr_q[RW-1]}}, xr_q});
	assign sy_sum = $signed({it_q.acc_vy[19], it_q.acc_vy}) + $signed({{2{yr_q[RW-1]}}, yr_q});
	assign yw     = yr_q * pos_w_q;

	assign dabs         = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
	assign div_dividend = {1'b0, dabs, {FRAC_BITS{1'b0}}} + {{(DVW-R2W+1){1'b0}}, r2_q[R2W-1:1]};
	assign r2_big       = r2_q > R2_MIN;

	assign t_val  = dneg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
	assign so_sum = $signed({{(SW-19){it_q.acc_omega[19]}}, it_q.acc_omega})
		+ (r2_big ? $signed({t_val[SW-1], t_val}) : '0);

	smk_divider #(
		.W (DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (r2_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = in_data.req_type ? ST_RPRE : ST_VMB;
			ST_VMB:   state_d = ST_VMW;
			ST_VMW:   state_d = ST_VPRE;
			ST_VPRE:  state_d = ((vix_q == '0) && (viy_q == '0)) ? ST_VFIN : ST_CWAIT;
			ST_RPRE:  state_d = ST_CWAIT;
			ST_CWAIT: if (cv[CORDIC_STEPS]) state_d = crot[CORDIC_STEPS] ? ST_RFIN : ST_VMAG;
			ST_VMAG:  state_d = ST_VFIN;
			ST_VFIN:  state_d = ST_OUT;
			ST_RFIN:  state_d = ST_R2A;
			ST_R2A:   state_d = ST_R2B;
			ST_R2B:   state_d = ST_PB;
			ST_PB:    state_d = ST_PW;
			ST_PW:    state_d = ST_DIVGO;
			ST_DIVGO: state_d = r2_big ? ST_DIV : ST_OMEGA;
			ST_DIV:   if (div_done) state_d = ST_OMEGA;
			ST_OMEGA: state_d = ST_OUT;
			ST_OUT:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_DIVGO) && r2_big;
		out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pos_w_q     <= '0;
			pos_b_q     <= '0;
			speed_q     <= '0;
			angle_q     <= '0;
		end else begin
			state_q <= state_d;
			start_q <= ((state_q == ST_VPRE) && !((vix_q == '0) && (viy_q == '0)))
				|| (state_q == ST_RPRE);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_POS_W: pos_w_q <= cfg_data;
					CFG_POS_B: pos_b_q <= cfg_data;
					default:   ;
				endcase
			end
			if (state_q == ST_VFIN) begin
				if (zero_q) begin
					speed_q <= '0;
					angle_q <= '0;
				end else begin
					if (m_rnd < 0) begin
						speed_q <= '0;
					end else if (m_rnd > 131071) begin
						speed_q <= 17'h1FFFF;
					end else begin
						speed_q <= m_rnd[16:0];
					end
					if (z_rnd > ANG_LIM) begin
						angle_q <= 16'(ANG_LIM);
					end else if (z_rnd < -ANG_LIM) begin
						angle_q <= -16'(ANG_LIM);
					end else begin
						angle_q <= z_rnd[15:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					it_q   <= in_data;
					flag_q <= 1'b0;
					svx_q  <= '0;
					svy_q  <= '0;
					som_q  <= '0;
				end
			end
			ST_VMB: vix_q <= vx_sum[VIW-1:0];
			ST_VMW: viy_q <= vy_sum[VIW-1:0];
			ST_VPRE: begin
				zero_q <= (vix_q == '0) && (viy_q == '0);
				rot0_q <= 1'b0;
				x0_q   <= $signed({{(XW-VIW-1){ax[VIW]}}, ax}) <<< GUARD;
				y0_q   <= $signed({{(XW-VIW-1){ay[VIW]}}, ay}) <<< GUARD;
				if (vix_q[VIW-1]) begin
					z0_q <= viy_q[VIW-1] ? -PI_Q30 : PI_Q30;
				end else begin
					z0_q <= '0;
				end
			end
			ST_RPRE: begin
				rot0_q <= 1'b1;
				x0_q   <= $signed({{(XW-26){1'b0}}, sp_rnd[55:30]});
				y0_q   <= '0;
				// fold into the right half plane, undo with a sign flip
				if (za > HALF_PI_Q30) begin
					z0_q  <= za - PI_Q30;
					neg_q <= 1'b1;
				end else if (za < -HALF_PI_Q30) begin
					z0_q  <= za + PI_Q30;
					neg_q <= 1'b1;
				end else begin
					z0_q  <= za;
					neg_q <= 1'b0;
				end
			end
			ST_VMAG: mprod_q <= cx[CORDIC_STEPS] * $signed({1'b0, INV_GAIN_Q30});
			ST_VFIN: begin
				if (!zero_q && ((m_rnd < 0) || (m_rnd > 131071))) begin
					flag_q <= 1'b1;
				end
			end
			ST_RFIN: begin
				xr_q <= neg_q ? -xs[RW-1:0] : xs[RW-1:0];
				yr_q <= neg_q ? -ys[RW-1:0] : ys[RW-1:0];
			end
			ST_R2A: begin
				r2_q   <= R2W'(ww);
				flag_q <= flag_q || (sx_sum > 21'sd524287) || (sx_sum < -21'sd524288)
					|| (sy_sum > 21'sd524287) || (sy_sum < -21'sd524288);
				if (sx_sum > 21'sd524287) begin
					svx_q <= 20'sd524287;
				end else if (sx_sum < -21'sd524288) begin
					svx_q <= -20'sd524288;
				end else begin
					svx_q <= sx_sum[19:0];
				end
				if (sy_sum > 21'sd524287) begin
					svy_q <= 20'sd524287;
				end else if (sy_sum < -21'sd524288) begin
					svy_q <= -20'sd524288;
				end else begin
					svy_q <= sy_sum[19:0];
				end
			end
			ST_R2B: r2_q <= r2_q + R2W'(bb);
			ST_PB:  pb_q <= xr_q * pos_b_q;
			ST_PW:  diff_q <= $signed({pb_q[34], pb_q}) - $signed({yw[34], yw});
			ST_DIVGO: dneg_q <= diff_q[DW-1];
			ST_OMEGA: begin
				if (so_sum > 524287) begin
					som_q  <= 20'sd524287;
					flag_q <= 1'b1;
				end else if (so_sum < -524288) begin
					som_q  <= -20'sd524288;
					flag_q <= 1'b1;
				end else begin
					som_q <= so_sum[19:0];
				end
			end
			ST_OUT: begin
				if (out_load) begin
					out_q.wheel_speed <= speed_q;
					out_q.wheel_angle <= angle_q;
					out_q.sum_vx      <= svx_q;
					out_q.sum_vy      <= svy_q;
					out_q.sum_omega   <= som_q;
					out_q.saturated   <= flag_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");
	a_chain_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cv[CORDIC_STEPS] |-> (state_q == ST_CWAIT))
		else $error("CORDIC chain beat arrived with no item waiting");
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((angle_q <= ANG_LIM) && (angle_q >= -ANG_LIM)))
		else $error("stored wheel angle out of range");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted beat did not start the sequencer");
`endif

endmodule

[rtl/core/smk_cordic_cell.sv]
`timescale 1ns / 1ps
// smk_cordic_cell: one registered CORDIC micro-rotation with a fixed shift.
// Depends on smk_pkg (angle width, arctangent table).
module smk_cordic_cell #(
	parameter int XW    = 31,
	parameter int SHIFT = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vld_in,
	input  logic                         rot_in,
	input  logic signed [XW-1:0]         x_in,
	input  logic signed [XW-1:0]         y_in,
	input  logic signed [smk_pkg::ZW-1:0] z_in,
	output logic                         vld_q,
	output logic                         rot_q,
	output logic signed [XW-1:0]         x_q,
	output logic signed [XW-1:0]         y_q,
	output logic signed [smk_pkg::ZW-1:0] z_q
);
	import smk_pkg::*;

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	logic signed [ZW-1:0] ang;
	logic                 dir;

	assign dx  = y_in >>> SHIFT;
	assign dy  = x_in >>> SHIFT;
	assign ang = $signed({{(ZW-30){1'b0}}, ATAN_TAB[SHIFT]});
	// rotate mode follows the sign of z, vectoring drives y toward zero
	assign dir = rot_in ? ~z_in[ZW-1] : (y_in[XW-1] || (y_in == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rot_q <= rot_in;
		if (dir) begin
			x_q <= x_in - dx;
			y_q <= y_in + dy;
			z_q <= z_in - ang;
		end else begin
			x_q <= x_in + dx;
			y_q <= y_in - dy;
			z_q <= z_in + ang;
		end
	end

endmodule

[rtl/core/smk_divider.sv]
`timescale 1ns / 1ps
// smk_divider: unsigned restoring divider, one quotient bit per cycle.
// Depends on smk_pkg (divisor width).
module smk_divider #(
	parameter int W = 49
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [W-1:0]           dividend,
	input  logic [smk_pkg::R2W-1:0] divisor,
	output logic                   done,
	output logic [W-1:0]           quotient
);
	import smk_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [R2W-1:0] rem_q;
	logic [R2W-1:0] dsr_q;
	logic [W-1:0]   quo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [R2W:0]   rem_sh;
	logic [R2W:0]   rem_sub;
	logic           fits;

	assign rem_sh  = {rem_q, quo_q[W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign fits    = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out the top as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[R2W-1:0] : rem_sh[R2W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[tb/swerve_module_kinematics_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for swerve_module_kinematics_unit: directed and random wheel-command and
// chassis-accumulate beats, checked against a behavioral fixed-point predictor.
// Depends on smk_pkg and the RTL top level.
module swerve_module_kinematics_unit_tb;
	import smk_pkg::*;

	localparam int NSTEP = 16;
	localparam int FRAC = 12;
	localparam longint R2_FLOOR = (64'd1 << (2 * FRAC)) / 1000000;
	localparam longint ATAN [24] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127
	};
	localparam longint PI30 = 64'd3373259426;
	localparam longint HPI30 = 64'd1686629713;
	localparam longint IGAIN = 64'd652032874;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	smk_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	smk_out_t out_data;

	swerve_module_kinematics_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// predictor state
	logic signed [15:0] off_w = 0, off_b = 0;
	logic [16:0] spd_held = 0;
	logic signed [15:0] ang_held = 0;

	smk_in_t cmd_q[$];
	smk_out_t wheel_expect_q[$];
	int errors = 0, n_sent = 0, n_seen = 0, n_sat = 0;
	bit hold_req = 0, hold_done = 0;
	int hold_left = 0;

	function automatic longint ashr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd(longint v, int s);
		if (s == 0)
			return v;
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi, ref bit f);
		if (v < lo) begin
			f = 1;
			return lo;
		end
		if (v > hi) begin
			f = 1;
			return hi;
		end
		return v;
	endfunction

	function automatic void polar_of(input longint x0, input longint y0, output longint mag,
			output longint ang);
		longint x, y, z, dx, dy;
		x = x0;
		y = y0;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			ang = 0;
			return;
		end
		if (x < 0) begin
			z = (y >= 0) ? PI30 : -PI30;
			x = -x;
			y = -y;
		end
		x = x * 256;
		y = y * 256;
		for (int i = 0; i < NSTEP; i++) begin
			dx = ashr(y, i);
			dy = ashr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += ATAN[i];
			end else begin
				x -= dx; y += dy; z -= ATAN[i];
			end
		end
		mag = rnd(x * IGAIN, 38);
		z = rnd(z, 17);
		if (z > ANG_LIM) z = ANG_LIM;
		if (z < -ANG_LIM) z = -ANG_LIM;
		ang = z;
	endfunction

	function automatic void cart_of(input longint spd, input longint ang, output longint ox,
			output longint oy);
		longint z, x, y, dx, dy;
		bit neg;
		z = ang * (longint'(1) << 17);
		y = 0;
		neg = 0;
		if (z > HPI30) begin
			z -= PI30; neg = 1;
		end else if (z < -HPI30) begin
			z += PI30; neg = 1;
		end
		x = rnd(spd * 256 * IGAIN, 30);
		for (int i = 0; i < NSTEP; i++) begin
			dx = ashr(y, i);
			dy = ashr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN[i];
			end else begin
				x += dx; y -= dy; z += ATAN[i];
			end
		end
		x = rnd(x, 8);
		y = rnd(y, 8);
		ox = neg ? -x : x;
		oy = neg ? -y : y;
	endfunction

	function automatic smk_out_t predict_wheel(smk_in_t c);
		smk_out_t r;
		longint w, b, vix, viy, mag, ang, x, y, r2, num, q, som;
		bit f;
		f = 0;
		w = off_w;
		b = off_b;
		r = '0;
		if (!c.req_type) begin
			vix = longint'(c.vel_x) + rnd(longint'(c.omega) * b, FRAC);
			viy = longint'(c.vel_y) - rnd(longint'(c.omega) * w, FRAC);
			polar_of(vix, viy, mag, ang);
			mag = clip(mag, 0, 131071, f);
			spd_held = mag[16:0];
			ang_held = ang[15:0];
		end else begin
			cart_of(longint'(spd_held), longint'(ang_held), x, y);
			r2 = w * w + b * b;
			r.sum_vx = 20'(clip(longint'(c.acc_vx) + x, -524288, 524287, f));
			r.sum_vy = 20'(clip(longint'(c.acc_vy) + y, -524288, 524287, f));
			som = longint'(c.acc_omega);
			if (r2 > R2_FLOOR) begin
				num = (x * b - y * w) * (longint'(1) << FRAC);
				q = ((num < 0 ? -num : num) + r2 / 2) / r2;
				som += (num < 0) ? -q : q;
			end
			r.sum_omega = 20'(clip(som, -524288, 524287, f));
		end
		r.wheel_speed = spd_held;
		r.wheel_angle = ang_held;
		r.saturated = f;
		return r;
	endfunction

	// accept flag captured at the rising edge so the driver never races the DUT
	logic in_ready_seen = 1'b0;

	// driver: bursts and gaps
	int burst = 0, gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready_seen) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					in_data <= cmd_q.pop_front();
					in_valid <= 1'b1;
					if (burst == 0) begin
						burst = $urandom_range(1, 12);
						gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
					end else
						burst--;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		in_ready_seen <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			wheel_expect_q.push_back(predict_wheel(in_data));
			n_sent++;
		end
	end

	// receiver stall pattern, plus one long hold counted here
	int stall_cnt = 0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left = 600;
			hold_done = 1;
			out_ready <= 1'b0;
		end else begin
			stall_cnt++;
			out_ready <= ((stall_cnt % 11) < 7) || ((stall_cnt / 64) % 3 == 0);
		end
	end

	// monitor
	always @(posedge clk) begin
		smk_out_t e;
		if (arst_n && out_valid && out_ready) begin
			n_seen++;
			if (wheel_expect_q.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				e = wheel_expect_q.pop_front();
				if (e.saturated) n_sat++;
				if (out_data.wheel_speed !== e.wheel_speed) begin
					$error("wheel_speed exp %0d got %0d", e.wheel_speed, out_data.wheel_speed);
					errors++;
				end
				if (out_data.wheel_angle !== e.wheel_angle) begin
					$error("wheel_angle exp %0d got %0d", e.wheel_angle, out_data.wheel_angle);
					errors++;
				end
				if (out_data.sum_vx !== e.sum_vx) begin
					$error("sum_vx exp %0d got %0d", e.sum_vx, out_data.sum_vx);
					errors++;
				end
				if (out_data.sum_vy !== e.sum_vy) begin
					$error("sum_vy exp %0d got %0d", e.sum_vy, out_data.sum_vy);
					errors++;
				end
				if (out_data.sum_omega !== e.sum_omega) begin
					$error("sum_omega exp %0d got %0d", e.sum_omega, out_data.sum_omega);
					errors++;
				end
				if (out_data.saturated !== e.saturated) begin
					$error("saturated exp %0d got %0d", e.saturated, out_data.saturated);
					errors++;
				end
			end
		end
	end

	function automatic smk_in_t mk(bit t, int vx, int vy, int om, int ax, int ay, int ao);
		smk_in_t c;
		c.req_type = t;
		c.vel_x = 16'(vx);
		c.vel_y = 16'(vy);
		c.omega = 16'(om);
		c.acc_vx = 20'(ax);
		c.acc_vy = 20'(ay);
		c.acc_omega = 20'(ao);
		return c;
	endfunction

	function automatic int rfield(int bits);
		case ($urandom_range(0, 5))
			0: return -(1 << (bits - 1));
			1: return (1 << (bits - 1)) - 1;
			2: return $signed($urandom_range(0, 400)) - 200;
			default: return $signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
		endcase
	endfunction

	function automatic smk_in_t rand_cmd();
		return mk(1'($urandom_range(0, 1)), rfield(16), rfield(16), rfield(16),
			rfield(20), rfield(20), rfield(20));
	endfunction

	task automatic drain();
		while (cmd_q.size() > 0 || in_valid || wheel_expect_q.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_offset(cfg_idx_t idx, logic signed [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_POS_W) off_w = v;
		else off_b = v;
	endtask

	initial begin
		logic signed [15:0] offs [6];
		offs = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sh0800, -16'sh0400, 16'sh0001};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// directed: zero offsets (small radius), zero vector, extremes
		cmd_q.push_back(mk(1, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(0, 32767, 32767, 0, 0, 0, 0));
		cmd_q.push_back(mk(1, 0, 0, 0, 524287, 524287, -524288));
		cmd_q.push_back(mk(0, -32768, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(0, -32768, -1, 0, 0, 0, 0));
		cmd_q.push_back(mk(1, 0, 0, 0, -524288, -524288, 524287));
		cmd_q.push_back(mk(0, 0, -32768, -1, 0, 0, 0));
		cmd_q.push_back(mk(1, -1, -1, -1, 1, -1, 0));
		drain();
		set_offset(CFG_POS_W, 16'sh0800);
		set_offset(CFG_POS_B, -16'sh0600);
		cmd_q.push_back(mk(0, 0, 0, 16'sh1000, 0, 0, 0));   // pure rotation
		cmd_q.push_back(mk(1, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(0, 0, 0, -32768, 0, 0, 0));
		cmd_q.push_back(mk(1, 0, 0, 0, 524287, -524288, 524287));
		// receiver holds off long while sender keeps offering
		hold_req = 1;
		for (int i = 0; i < 12; i++) cmd_q.push_back(rand_cmd());
		wait (hold_done);
		drain();
		for (int p = 0; p < 8; p++) begin
			set_offset(CFG_POS_W, (p < 6) ? offs[p] : 16'(rfield(16)));
			set_offset(CFG_POS_B, (p < 6) ? offs[5 - p] : 16'(rfield(16)));
			// mostly set-then-accumulate pairs
			for (int i = 0; i < 52; i++) begin
				smk_in_t c;
				c = rand_cmd();
				if (i % 2 == 0) c.req_type = 0;
				cmd_q.push_back(c);
			end
			drain();
		end
		$display("Covered %0d beats over 10 offset settings, %0d saturating results.",
			n_sent, n_sat);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end
endmodule

[sim.f]
rtl/core/smk_pkg.sv
rtl/core/smk_cordic_cell.sv
rtl/core/smk_divider.sv
rtl/core/swerve_module_kinematics_unit.sv
tb/swerve_module_kinematics_unit_tb.sv
